// ===== rtl/wdnd_pkg.sv =====
`timescale 1ns / 1ps

package wdnd_pkg;

  localparam int WINDOW_DEF = 8;
  localparam int SAMPLE_W   = 16;

  // opcode field
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_CONNECT = 1'b1;

  // cause field
  localparam logic CAUSE_SAMPLES = 1'b0;
  localparam logic CAUSE_CONNECT = 1'b1;

  // register index (paddr[2])
  localparam logic REG_DAY   = 1'b0;
  localparam logic REG_NIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // chain control: shift moves every cell by one, load picks the new sample
  // as the head input instead of the recirculated tail
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctrl_t;

endpackage

// ===== rtl/windowed_day_night_detector_core.sv =====
`timescale 1ns / 1ps
// Path: a connect report (connected set) goes ST_IDLE, ST_EMIT, then the out_valid register;
//   a light sample with a mode change goes ST_IDLE (accept), ST_SCAN, ST_EMIT, out_valid.
// Throughput: one request at a time; once the window is full, a sample is followed by the
//   scan that rotates the cell chain once past the compare unit, then ST_EMIT with a result.
// Reset (rst, synchronous, active high): day mode, empty window, thresholds 65535 / 0.
module windowed_day_night_detector_core #(
  parameter int WINDOW = wdnd_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [wdnd_pkg::SAMPLE_W-1:0] light_sample,
  input  logic                          connected,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          night_mode,
  output logic                          cause,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wdnd_pkg::*;

  localparam int FW = $clog2(WINDOW + 1);  // fill count holds 0..WINDOW
  localparam int CW = $clog2(WINDOW);      // scan count 0..WINDOW-1
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW);
  localparam logic [CW-1:0] SCAN_LAST = CW'(WINDOW - 1);

  // ---------------- configuration ----------------
  logic [SAMPLE_W-1:0] day_thr;
  logic [SAMPLE_W-1:0] night_thr;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_thr   <= '1;
      night_thr <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DAY:   day_thr   <= pwdata[SAMPLE_W-1:0];
        REG_NIGHT: night_thr <= pwdata[SAMPLE_W-1:0];
        default:   ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_NIGHT) ? {{(32-SAMPLE_W){1'b0}}, night_thr}
                                          : {{(32-SAMPLE_W){1'b0}}, day_thr};

  // ---------------- sample window ----------------
  // Order inside the window does not matter for the all-dark / all-bright
  // check, so the ring is kept as a shift chain. A scan rotates it a full
  // turn, comparing the tail cell each cycle.
  chain_ctrl_t         ctrl;
  logic [SAMPLE_W-1:0] tail;

  wdnd_chain #(.WINDOW(WINDOW)) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .sample_in (light_sample),
    .tail      (tail)
  );

  // ---------------- control ----------------
  state_t        state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [CW-1:0] scan_cnt, scan_cnt_next;
  logic          dark_acc, dark_acc_next;
  logic          bright_acc, bright_acc_next;
  logic          night_active, night_active_next;
  logic          pend_mode, pend_mode_next;
  logic          pend_cause, pend_cause_next;
  logic          load_out;
  logic          dark_hit, bright_hit;
  logic          all_dark, all_bright;

  assign dark_hit   = (tail <= night_thr);
  assign bright_hit = (tail >= day_thr);
  assign all_dark   = dark_acc & dark_hit;
  assign all_bright = bright_acc & bright_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      night_active <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      night_active <= night_active_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt   <= scan_cnt_next;
    dark_acc   <= dark_acc_next;
    bright_acc <= bright_acc_next;
    pend_mode  <= pend_mode_next;
    pend_cause <= pend_cause_next;
  end

  always_comb begin
    state_next        = state;
    fill_next         = fill;
    scan_cnt_next     = scan_cnt;
    dark_acc_next     = dark_acc;
    bright_acc_next   = bright_acc;
    night_active_next = night_active;
    pend_mode_next    = pend_mode;
    pend_cause_next   = pend_cause;
    ctrl              = '0;
    in_ready          = 1'b0;
    load_out          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == OP_CONNECT) begin
            if (connected) begin
              pend_mode_next  = night_active;
              pend_cause_next = CAUSE_CONNECT;
              state_next      = ST_EMIT;
            end
          end else begin
            ctrl.shift = 1'b1;
            ctrl.load  = 1'b1;
            if (fill != FILL_FULL) begin
              fill_next = fill + 1'b1;
            end
            // window counts as filled on the WINDOW-th sample
            if (fill_next == FILL_FULL) begin
              scan_cnt_next   = '0;
              dark_acc_next   = 1'b1;
              bright_acc_next = 1'b1;
              state_next      = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        ctrl.shift      = 1'b1;
        dark_acc_next   = all_dark;
        bright_acc_next = all_bright;
        scan_cnt_next   = scan_cnt + 1'b1;
        if (scan_cnt == SCAN_LAST) begin
          state_next = ST_IDLE;
          // both checks true: mode left alone
          if (!(all_dark && all_bright)) begin
            if (all_bright && night_active) begin
              night_active_next = 1'b0;
              pend_mode_next    = 1'b0;
              pend_cause_next   = CAUSE_SAMPLES;
              state_next        = ST_EMIT;
            end else if (all_dark && !night_active) begin
              night_active_next = 1'b1;
              pend_mode_next    = 1'b1;
              pend_cause_next   = CAUSE_SAMPLES;
              state_next        = ST_EMIT;
            end
          end
        end
      end

      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      night_mode <= pend_mode;
      cause      <= pend_cause;
    end
  end

endmodule

// ===== rtl/wdnd_cell.sv =====
`timescale 1ns / 1ps

module wdnd_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wdnd_pkg::SAMPLE_W-1:0] d,
  output logic [wdnd_pkg::SAMPLE_W-1:0] q
);
  import wdnd_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/wdnd_chain.sv =====
`timescale 1ns / 1ps

module wdnd_chain #(
  parameter int WINDOW = wdnd_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  wdnd_pkg::chain_ctrl_t         ctrl,
  input  logic [wdnd_pkg::SAMPLE_W-1:0] sample_in,
  output logic [wdnd_pkg::SAMPLE_W-1:0] tail
);
  import wdnd_pkg::*;

  logic [SAMPLE_W-1:0] cell_q [WINDOW];
  logic [SAMPLE_W-1:0] head;

  // head takes a new sample or the tail (rotate during scan)
  assign head = ctrl.load ? sample_in : tail;
  assign tail = cell_q[WINDOW-1];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      wdnd_cell u_cell (
        .clk (clk),
        .en  (ctrl.shift),
        .d   (head),
        .q   (cell_q[i])
      );
    end else begin : g_body
      wdnd_cell u_cell (
        .clk (clk),
        .en  (ctrl.shift),
        .d   (cell_q[i-1]),
        .q   (cell_q[i])
      );
    end
  end

endmodule

// ===== rtl/wdnd_checker.sv =====
`timescale 1ns / 1ps

module wdnd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic opcode,
  input logic connected,
  input logic out_valid,
  input logic out_ready,
  input logic night_mode,
  input logic cause
);
  import wdnd_pkg::*;

  // last mode seen on the result channel, day after reset
  logic last_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_mode <= night_mode;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(night_mode) && $stable(cause))
    else $error("result changed while stalled");

  a_connect_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_CONNECT && connected |=> !in_ready)
    else $error("request taken while connect report pending");

  a_change_flips: assert property (@(posedge clk) disable iff (rst)
    out_valid && cause == CAUSE_SAMPLES |-> night_mode != last_mode)
    else $error("sample result does not change the mode");

  a_report_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid && cause == CAUSE_CONNECT |-> night_mode == last_mode)
    else $error("connect report disagrees with last mode");

endmodule

bind windowed_day_night_detector_core wdnd_checker u_wdnd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .opcode     (opcode),
  .connected  (connected),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .night_mode (night_mode),
  .cause      (cause)
);
